>>> sv/bal_pkg.sv
package bal_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 4;
    localparam int CAP_W = 5;
    localparam int TOT_W = 5;
    localparam int VAL_W = 32;
    // Width wide enough to compare a position against the count.
    localparam int AT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    // Width wide enough to compare the count against the capacity.
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_INSERT_AT  = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_BACK   = 3'd4;
    localparam logic [2:0] CMD_REMOVE_AT  = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef struct packed {
        logic [2:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } bal_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] taken_value;
        logic [1:0]              status;
        logic [TOT_W-1:0]        entry_total;
    } bal_rsp_t;

    // Broadcast to every cell of the row in the cycle a request is taken.
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic [AT_W-1:0]         at;
        logic [AT_W-1:0]         cnt;
        logic signed [VAL_W-1:0] value;
    } bal_shift_t;

    function automatic logic [TOT_W-1:0] to_total(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[TOT_W-1:0];
    endfunction

endpackage

>>> sv/bal_cell.sv
module bal_cell (
    input  logic                             aclk,
    input  bal_pkg::bal_shift_t              shift,
    input  logic [bal_pkg::IDX_W-1:0]        cell_idx,
    input  logic signed [bal_pkg::VAL_W-1:0] left_data,
    input  logic signed [bal_pkg::VAL_W-1:0] right_data,
    output logic signed [bal_pkg::VAL_W-1:0] data
);

    logic signed [bal_pkg::VAL_W-1:0] data_reg;
    logic signed [bal_pkg::VAL_W-1:0] data_next;
    logic [bal_pkg::AT_W-1:0]         idx;

    assign idx  = bal_pkg::AT_W'(cell_idx);
    assign data = data_reg;

    // Insert opens a gap at the insert point; remove closes the gap.
    always_comb begin
        data_next = data_reg;
        if (shift.ins) begin
            if (idx == shift.at) begin
                data_next = shift.value;
            end else if (idx > shift.at && idx <= shift.cnt) begin
                data_next = left_data;
            end
        end else if (shift.rem) begin
            if (idx >= shift.at && (idx + bal_pkg::AT_W'(1)) < shift.cnt) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

>>> sv/bal_ctrl.sv
module bal_ctrl (
    input  logic                         fire,
    input  bal_pkg::bal_req_t            req,
    input  logic [bal_pkg::CNT_W-1:0]    count,
    input  logic [bal_pkg::CAP_W-1:0]    capacity,
    output bal_pkg::bal_shift_t          shift,
    output logic [1:0]                   status,
    output logic [bal_pkg::CNT_W-1:0]    count_next
);

    logic                      is_ins;
    logic                      is_rem;
    logic                      full;
    logic                      empty;
    logic [bal_pkg::AT_W-1:0]  cnt_ext;
    logic [bal_pkg::AT_W-1:0]  at;
    logic                      ok;

    assign cnt_ext = bal_pkg::AT_W'(count);
    assign full    = (bal_pkg::LIM_W'(count) >= bal_pkg::LIM_W'(capacity))
                  || (count == bal_pkg::CNT_W'(bal_pkg::DEPTH));
    assign empty   = (count == '0);

    always_comb begin
        is_ins = 1'b0;
        is_rem = 1'b0;
        at     = '0;
        unique case (req.command)
            bal_pkg::CMD_PUSH_FRONT: begin
                is_ins = 1'b1;
            end
            bal_pkg::CMD_PUSH_BACK: begin
                is_ins = 1'b1;
                at     = cnt_ext;
            end
            bal_pkg::CMD_INSERT_AT: begin
                is_ins = 1'b1;
                at     = bal_pkg::AT_W'(req.position);
            end
            bal_pkg::CMD_POP_FRONT: begin
                is_rem = 1'b1;
            end
            bal_pkg::CMD_POP_BACK: begin
                is_rem = 1'b1;
                at     = cnt_ext - bal_pkg::AT_W'(1);
            end
            bal_pkg::CMD_REMOVE_AT: begin
                is_rem = 1'b1;
                at     = bal_pkg::AT_W'(req.position);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        status = bal_pkg::ST_DONE;
        if (is_ins) begin
            if (full) begin
                status = bal_pkg::ST_FULL;
            end else if (at > cnt_ext) begin
                status = bal_pkg::ST_RANGE;
            end
        end else if (is_rem) begin
            if (empty) begin
                status = bal_pkg::ST_EMPTY;
            end else if (at >= cnt_ext) begin
                status = bal_pkg::ST_RANGE;
            end
        end
    end

    assign ok          = fire && (status == bal_pkg::ST_DONE);
    assign shift.ins   = ok && is_ins;
    assign shift.rem   = ok && is_rem;
    assign shift.at    = at;
    assign shift.cnt   = cnt_ext;
    assign shift.value = req.value;

    always_comb begin
        count_next = count;
        if (shift.ins) begin
            count_next = count + bal_pkg::CNT_W'(1);
        end else if (shift.rem) begin
            count_next = count - bal_pkg::CNT_W'(1);
        end
    end

endmodule

>>> sv/bounded_array_list.sv
// Result: the result of an accepted request is registered into m_result and
// is shown there in the cycle after the request is accepted.
// Throughput: one request per cycle while m_ready is high; the row shifts every
// entry in the same cycle, and a request enters in the cycle a result is taken.
// Reset: aresetn is synchronous and active low; it empties the list, drops the
// pending result and sets the capacity to 16. Entry contents are not cleared.
module bounded_array_list (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bal_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bal_pkg::bal_req_t             s_request,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bal_pkg::bal_rsp_t             m_result
);

    // Control state: the entry count, the capacity register and the output
    // stage valid flag. The entries themselves live in the row of cells.
    logic [bal_pkg::CNT_W-1:0] count_reg;
    logic [bal_pkg::CNT_W-1:0] count_next;
    logic [bal_pkg::CAP_W-1:0] capacity_reg;
    logic                      m_valid_reg;
    bal_pkg::bal_rsp_t         m_result_reg;

    logic                      fire;
    bal_pkg::bal_shift_t       shift;
    logic [1:0]                status;
    logic signed [bal_pkg::VAL_W-1:0] cell_data [bal_pkg::DEPTH];
    logic signed [bal_pkg::VAL_W-1:0] taken;

    // A request may enter whenever the output register is empty or is being
    // drained in this same cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign fire     = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // The controller decodes the command, checks full, empty and position
    // against the current count, and broadcasts the shift order to the row.
    bal_ctrl u_ctrl (
        .fire       (fire),
        .req        (s_request),
        .count      (count_reg),
        .capacity   (capacity_reg),
        .shift      (shift),
        .status     (status),
        .count_next (count_next)
    );

    // Row of cells: cell k holds entry k and sees both neighbors. The ends of
    // the row are fed zeros, which no legal shift ever takes.
    for (genvar k = 0; k < bal_pkg::DEPTH; k++) begin : g_cell
        logic signed [bal_pkg::VAL_W-1:0] left_in;
        logic signed [bal_pkg::VAL_W-1:0] right_in;

        if (k == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_mid_l
            assign left_in = cell_data[k-1];
        end

        if (k == bal_pkg::DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_mid_r
            assign right_in = cell_data[k+1];
        end

        bal_cell u_cell (
            .aclk       (aclk),
            .shift      (shift),
            .cell_idx   (bal_pkg::IDX_W'(k)),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[k])
        );
    end

    // The removed entry is read from the row before it shifts. A failed
    // remove, or any insert, returns zero.
    always_comb begin
        taken = '0;
        if (shift.rem) begin
            taken = cell_data[shift.at[bal_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            capacity_reg <= bal_pkg::CAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_result_reg.taken_value <= taken;
            m_result_reg.status      <= status;
            m_result_reg.entry_total <= bal_pkg::to_total(count_next);
        end
    end

endmodule

>>> sv/bal_checker.sv
module bal_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input bal_pkg::bal_req_t         s_request,
    input logic                      m_valid,
    input logic                      m_ready,
    input bal_pkg::bal_rsp_t         m_result
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result changed while stalled");

    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.status != bal_pkg::ST_DONE |-> m_result.taken_value == '0)
        else $error("failed command returned a value");

    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_result.entry_total) <= 32'(bal_pkg::DEPTH))
        else $error("entry total above depth");

    a_push_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_request.command <= bal_pkg::CMD_INSERT_AT
        |=> m_result.status != bal_pkg::ST_EMPTY)
        else $error("insert reported empty");

endmodule

bind bounded_array_list bal_checker u_bal_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_request (s_request),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_result  (m_result)
);
